@@ sv/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsv2rgb_pkg
// Shared widths, constants, beat types and the clamp and sector helpers for the
// HSV to RGB converter pipeline.
// ============================================================================
package hsv2rgb_pkg;

    localparam int HUE_W  = 17;
    localparam int FRAC_W = 9;   // saturation and brightness, 256 = 1.0
    localparam int SEC_W  = 4;   // sector 0..8
    localparam int F_W    = 14;  // fraction 0..15359
    localparam int Y_W    = 22;  // component over 256*15360
    localparam int PROD_W = 31;  // brightness times component
    localparam int CHAN_W = 8;

    localparam logic [F_W-1:0]    SECTOR_SPAN = 14'd15360;
    localparam logic [FRAC_W-1:0] ONE_Q8      = 9'd256;
    localparam logic [Y_W-1:0]    FULL_NUM    = 22'd3932160;

    // Sector codes. Anything from five upward maps like the last sector.
    localparam logic [SEC_W-1:0] SECTOR_0 = 4'd0;
    localparam logic [SEC_W-1:0] SECTOR_1 = 4'd1;
    localparam logic [SEC_W-1:0] SECTOR_2 = 4'd2;
    localparam logic [SEC_W-1:0] SECTOR_3 = 4'd3;
    localparam logic [SEC_W-1:0] SECTOR_4 = 4'd4;

    typedef struct packed {
        logic [SEC_W-1:0]  sector;
        logic [F_W-1:0]    frac;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
    } t_sec_beat;

    typedef struct packed {
        logic [FRAC_W-1:0] val;
        logic [Y_W-1:0]    y_red;
        logic [Y_W-1:0]    y_green;
        logic [Y_W-1:0]    y_blue;
    } t_mix_beat;

    // Clamps a 9-bit fraction to 1.0.
    function automatic logic [FRAC_W-1:0] clamp_one(input logic [FRAC_W-1:0] x);
        return x[FRAC_W-1] ? ONE_Q8 : x;
    endfunction

    // Hue divided by 60 degrees: the largest k with k*15360 <= hue.
    function automatic logic [SEC_W-1:0] sector_of(input logic [HUE_W-1:0] hue);
        logic [SEC_W-1:0] sec;
        sec = '0;
        for (int k = 1; k <= 8; k++) begin
            if (hue >= HUE_W'(k * 15360)) begin
                sec = SEC_W'(k);
            end
        end
        return sec;
    endfunction

endpackage

@@ sv/hsv2rgb_sector.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsv2rgb_sector
// First pipeline stage: clamps the fractions and splits the hue into a
// sector and a fraction within the sector.
// ============================================================================
module hsv2rgb_sector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]       i_hue,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]      i_sat,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]      i_val,
    output logic                                o_valid,
    input  logic                                i_ready,
    output hsv2rgb_pkg::t_sec_beat              o_beat
);

    logic                         r_vld;
    hsv2rgb_pkg::t_sec_beat       r_beat;
    hsv2rgb_pkg::t_sec_beat       n_beat;
    logic [hsv2rgb_pkg::SEC_W-1:0] sec;
    logic [hsv2rgb_pkg::HUE_W-1:0] base;
    logic                         adv;

    // Sector times fifteen, seven bits wide so it sits above the ten zero bits.
    function automatic logic [6:0] HUE_W_ZERO_PAD(input logic [hsv2rgb_pkg::SEC_W-1:0] s);
        return 7'({3'd0, s} * 7'd15);
    endfunction

    assign adv     = !r_vld || i_ready;
    assign o_ready = adv;

    always_comb begin
        sec  = hsv2rgb_pkg::sector_of(i_hue);
        // sector * 15360 = (sector * 15) << 10
        base = {HUE_W_ZERO_PAD(sec), 10'd0};
        n_beat.sector = sec;
        n_beat.frac   = hsv2rgb_pkg::F_W'(i_hue - base);
        n_beat.sat    = hsv2rgb_pkg::clamp_one(i_sat);
        n_beat.val    = hsv2rgb_pkg::clamp_one(i_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_vld;
    assign o_beat  = r_beat;

endmodule

@@ sv/hsv2rgb_blend.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsv2rgb_blend
// Two stages: the saturation products, then p, q, t and the sector mapping
// onto the three channel components.
// ============================================================================
module hsv2rgb_blend (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  hsv2rgb_pkg::t_sec_beat i_beat,
    output logic                   o_valid,
    input  logic                   i_ready,
    output hsv2rgb_pkg::t_mix_beat o_beat
);

    logic                              r_a_vld;
    logic [hsv2rgb_pkg::SEC_W-1:0]     r_a_sector;
    logic [hsv2rgb_pkg::FRAC_W-1:0]    r_a_val;
    logic [hsv2rgb_pkg::Y_W-1:0]       r_a_sf;
    logic [hsv2rgb_pkg::Y_W-1:0]       r_a_st;
    logic [hsv2rgb_pkg::Y_W-1:0]       r_a_yp;
    logic [hsv2rgb_pkg::Y_W-1:0]       n_a_sf;
    logic [hsv2rgb_pkg::Y_W-1:0]       n_a_st;
    logic [hsv2rgb_pkg::Y_W-1:0]       n_a_yp;

    logic                              r_b_vld;
    hsv2rgb_pkg::t_mix_beat            r_b_beat;
    hsv2rgb_pkg::t_mix_beat            n_b_beat;
    logic [hsv2rgb_pkg::Y_W-1:0]       yq;
    logic [hsv2rgb_pkg::Y_W-1:0]       yt;

    logic                              adv_a;
    logic                              adv_b;

    assign adv_b   = !r_b_vld || i_ready;
    assign adv_a   = !r_a_vld || adv_b;
    assign o_ready = adv_a;

    always_comb begin
        n_a_sf = hsv2rgb_pkg::Y_W'({13'd0, i_beat.sat} * {8'd0, i_beat.frac});
        n_a_st = hsv2rgb_pkg::Y_W'({13'd0, i_beat.sat}
                 * {8'd0, hsv2rgb_pkg::SECTOR_SPAN - i_beat.frac});
        n_a_yp = hsv2rgb_pkg::Y_W'({13'd0, hsv2rgb_pkg::ONE_Q8 - i_beat.sat}
                 * {8'd0, hsv2rgb_pkg::SECTOR_SPAN});
    end

    always_comb begin
        yq = hsv2rgb_pkg::FULL_NUM - r_a_sf;
        yt = hsv2rgb_pkg::FULL_NUM - r_a_st;
        n_b_beat.val = r_a_val;
        case (r_a_sector)
            hsv2rgb_pkg::SECTOR_0: begin
                n_b_beat.y_red   = hsv2rgb_pkg::FULL_NUM;
                n_b_beat.y_green = yt;
                n_b_beat.y_blue  = r_a_yp;
            end
            hsv2rgb_pkg::SECTOR_1: begin
                n_b_beat.y_red   = yq;
                n_b_beat.y_green = hsv2rgb_pkg::FULL_NUM;
                n_b_beat.y_blue  = r_a_yp;
            end
            hsv2rgb_pkg::SECTOR_2: begin
                n_b_beat.y_red   = r_a_yp;
                n_b_beat.y_green = hsv2rgb_pkg::FULL_NUM;
                n_b_beat.y_blue  = yt;
            end
            hsv2rgb_pkg::SECTOR_3: begin
                n_b_beat.y_red   = r_a_yp;
                n_b_beat.y_green = yq;
                n_b_beat.y_blue  = hsv2rgb_pkg::FULL_NUM;
            end
            hsv2rgb_pkg::SECTOR_4: begin
                n_b_beat.y_red   = yt;
                n_b_beat.y_green = r_a_yp;
                n_b_beat.y_blue  = hsv2rgb_pkg::FULL_NUM;
            end
            default: begin
                n_b_beat.y_red   = hsv2rgb_pkg::FULL_NUM;
                n_b_beat.y_green = r_a_yp;
                n_b_beat.y_blue  = yq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_vld <= i_valid;
            end
            if (adv_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) begin
            r_a_sector <= i_beat.sector;
            r_a_val    <= i_beat.val;
            r_a_sf     <= n_a_sf;
            r_a_st     <= n_a_st;
            r_a_yp     <= n_a_yp;
        end
        if (adv_b && r_a_vld) begin
            r_b_beat <= n_b_beat;
        end
    end

    assign o_valid = r_b_vld;
    assign o_beat  = r_b_beat;

endmodule

@@ sv/hsv2rgb_scale.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsv2rgb_scale
// Two stages: brightness times each component, then the scaling to
// floor(255 * component), which is 17 * product >> 26, capped at 255.
// ============================================================================
module hsv2rgb_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  hsv2rgb_pkg::t_mix_beat            i_beat,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_blue
);

    localparam int WIDE_W = hsv2rgb_pkg::PROD_W + 5;

    logic                                r_a_vld;
    logic [hsv2rgb_pkg::PROD_W-1:0]      r_a_prod [3];
    logic [hsv2rgb_pkg::PROD_W-1:0]      n_a_prod [3];
    logic [hsv2rgb_pkg::Y_W-1:0]         comp [3];

    logic                                r_b_vld;
    logic [hsv2rgb_pkg::CHAN_W-1:0]      r_b_chan [3];
    logic [hsv2rgb_pkg::CHAN_W-1:0]      n_b_chan [3];
    logic [WIDE_W-1:0]                   wide [3];

    logic                                adv_a;
    logic                                adv_b;

    assign adv_b   = !r_b_vld || i_ready;
    assign adv_a   = !r_a_vld || adv_b;
    assign o_ready = adv_a;

    always_comb begin
        comp[0] = i_beat.y_red;
        comp[1] = i_beat.y_green;
        comp[2] = i_beat.y_blue;
        for (int c = 0; c < 3; c++) begin
            n_a_prod[c] = hsv2rgb_pkg::PROD_W'(
                {22'd0, i_beat.val} * {9'd0, comp[c]});
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            wide[c] = {r_a_prod[c], 4'd0, 1'b0} >> 1;
            wide[c] = wide[c] + {5'd0, r_a_prod[c]};
            if (wide[c][WIDE_W-1:26] > 10'd255) begin
                n_b_chan[c] = 8'd255;
            end else begin
                n_b_chan[c] = wide[c][33:26];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_vld <= i_valid;
            end
            if (adv_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) begin
            r_a_prod <= n_a_prod;
        end
        if (adv_b && r_a_vld) begin
            r_b_chan <= n_b_chan;
        end
    end

    assign o_valid = r_b_vld;
    assign o_red   = r_b_chan[0];
    assign o_green = r_b_chan[1];
    assign o_blue  = r_b_chan[2];

endmodule

@@ sv/hsv_to_rgb_converter_top.sv @@
`timescale 1ns / 1ps
// Throughput: one pixel per clock; each of the five stages takes a new
// beat whenever it is empty or its content moves on, so a stall at the
// output fills the empty stages before the input ready drops.
// Reset: i_rst_n is synchronous and active low; it clears every stage's
// valid bit, data registers are not reset.
// ============================================================================
// hsv_to_rgb_converter_top
// Converts one HSV pixel per beat into one RGB pixel.
// ============================================================================
module hsv_to_rgb_converter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]       i_hue,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]      i_saturation,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]      i_brightness,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]      o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]      o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]      o_blue
);

    // The whole conversion is exact integer math. Every component is
    // brightness times a value Y over 256*15360, and the channel is
    // floor(255 * v * Y / 2^16 / 15360) = (17 * v * Y) >> 26. Zero
    // saturation makes p, q and t all equal to v, so grey needs no
    // separate path.

    logic                   sec_valid;
    logic                   sec_ready;
    hsv2rgb_pkg::t_sec_beat sec_beat;
    logic                   mix_valid;
    logic                   mix_ready;
    hsv2rgb_pkg::t_mix_beat mix_beat;

    // Stage 1: clamp s and v, split the hue into sector and fraction.
    hsv2rgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_hue   (i_hue),
        .i_sat   (i_saturation),
        .i_val   (i_brightness),
        .o_valid (sec_valid),
        .i_ready (sec_ready),
        .o_beat  (sec_beat)
    );

    // Stages 2 and 3: saturation products, then p, q, t and the mapping.
    hsv2rgb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sec_valid),
        .o_ready (sec_ready),
        .i_beat  (sec_beat),
        .o_valid (mix_valid),
        .i_ready (mix_ready),
        .o_beat  (mix_beat)
    );

    // Stages 4 and 5: brightness products and the scaling to 8 bits. The
    // last stage is the output register that holds a beat under a stall.
    hsv2rgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .o_ready (mix_ready),
        .i_beat  (mix_beat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the HSV to RGB pixel converter. HSV beats are sent
// through the valid/ready input port, and an RGB value is computed for each
// accepted beat with exact integer arithmetic. Every RGB beat that leaves the
// block is compared channel by channel with the oldest prediction. The
// stimulus covers sector boundaries, grey pixels, out-of-range hue,
// saturation and brightness, random pixels with idle cycles on both sides,
// a long output hold-off and a stretch at full rate.
// ============================================================================
module tb_top;

    // The block holds five beats. The watchdog limit covers the longest
    // output hold-off several times over.
    localparam int LATENCY_CYC  = 5;
    localparam int HOLD_CYC     = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BEATS = 1000;

    typedef struct packed {
        logic [hsv2rgb_pkg::CHAN_W-1:0] red;
        logic [hsv2rgb_pkg::CHAN_W-1:0] green;
        logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
    } t_rgb_pixel;

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_in_valid   = 1'b0;
    logic                             o_in_ready;
    logic [hsv2rgb_pkg::HUE_W-1:0]    i_hue        = '0;
    logic [hsv2rgb_pkg::FRAC_W-1:0]   i_saturation = '0;
    logic [hsv2rgb_pkg::FRAC_W-1:0]   i_brightness = '0;
    logic                             o_out_valid;
    logic                             i_out_ready  = 1'b0;
    logic [hsv2rgb_pkg::CHAN_W-1:0]   o_red;
    logic [hsv2rgb_pkg::CHAN_W-1:0]   o_green;
    logic [hsv2rgb_pkg::CHAN_W-1:0]   o_blue;

    // Random idle cycles on either side can be switched off for a stretch.
    bit                  in_idle_en   = 1'b1;
    bit                  out_idle_en  = 1'b1;
    // Cycles left in a forced output hold-off; counted down by the receiver.
    int                  hold_left    = 0;

    t_rgb_pixel          rgb_expected_q[$];
    int                  pixels_sent    = 0;
    int                  pixels_checked = 0;
    int                  grey_sent      = 0;
    int                  fail_count     = 0;
    int                  quiet_cycles   = 0;

    hsv_to_rgb_converter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Color math
    // ------------------------------------------------------------------------

    // Scales a component held over 256*256*15360 to an 8-bit channel,
    // rounding down and capping at 255.
    function automatic logic [hsv2rgb_pkg::CHAN_W-1:0] scale_to_byte(
        input longint unsigned num);
        longint unsigned span  = hsv2rgb_pkg::SECTOR_SPAN;
        longint unsigned one   = hsv2rgb_pkg::ONE_Q8;
        longint unsigned level;
        level = (num * 255) / (one * one * span);
        return (level > 255) ? 8'd255 : hsv2rgb_pkg::CHAN_W'(level);
    endfunction

    // Computes the RGB pixel for one HSV pixel. Saturation and brightness
    // above 1.0 count as 1.0; any sector past the fifth maps like the fifth.
    function automatic t_rgb_pixel hsv_to_rgb(
        input logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
        input logic [hsv2rgb_pkg::FRAC_W-1:0] sat_in,
        input logic [hsv2rgb_pkg::FRAC_W-1:0] val_in);
        longint unsigned  span = hsv2rgb_pkg::SECTOR_SPAN;
        longint unsigned  one  = hsv2rgb_pkg::ONE_Q8;
        longint unsigned  full = hsv2rgb_pkg::FULL_NUM;
        longint unsigned  sat, val, frac, c_val, c_p, c_q, c_t, c_r, c_g, c_b;
        logic [hsv2rgb_pkg::SEC_W-1:0] sector;
        t_rgb_pixel       pix;
        sat   = (sat_in > hsv2rgb_pkg::ONE_Q8) ? one : longint'(sat_in);
        val   = (val_in > hsv2rgb_pkg::ONE_Q8) ? one : longint'(val_in);
        c_val = val * full;
        if (sat == 0) begin
            pix.red   = scale_to_byte(c_val);
            pix.green = pix.red;
            pix.blue  = pix.red;
            return pix;
        end
        sector = hsv2rgb_pkg::SEC_W'(longint'(hue) / span);
        frac   = longint'(hue) % span;
        c_p    = val * (one - sat) * span;
        c_q    = val * (full - sat * frac);
        c_t    = val * (full - sat * (span - frac));
        case (sector)
            hsv2rgb_pkg::SECTOR_0: begin c_r = c_val; c_g = c_t;   c_b = c_p;   end
            hsv2rgb_pkg::SECTOR_1: begin c_r = c_q;   c_g = c_val; c_b = c_p;   end
            hsv2rgb_pkg::SECTOR_2: begin c_r = c_p;   c_g = c_val; c_b = c_t;   end
            hsv2rgb_pkg::SECTOR_3: begin c_r = c_p;   c_g = c_q;   c_b = c_val; end
            hsv2rgb_pkg::SECTOR_4: begin c_r = c_t;   c_g = c_p;   c_b = c_val; end
            default: begin c_r = c_val; c_g = c_p;   c_b = c_q;   end
        endcase
        pix.red   = scale_to_byte(c_r);
        pix.green = scale_to_byte(c_g);
        pix.blue  = scale_to_byte(c_b);
        return pix;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one HSV beat and returns at the rising edge that accepts it.
    // The payload moves only at a falling edge, and valid is not dropped
    // after acceptance, so back-to-back beats with no idle cycle keep valid high.
    task automatic send_pixel(input logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
                              input logic [hsv2rgb_pkg::FRAC_W-1:0] sat,
                              input logic [hsv2rgb_pkg::FRAC_W-1:0] val);
        @(negedge i_clk);
        while (in_idle_en && $urandom_range(99) < 7) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_hue        = hue;
        i_saturation = sat;
        i_brightness = val;
        do @(posedge i_clk); while (!o_in_ready);
        rgb_expected_q.push_back(hsv_to_rgb(hue, sat, val));
        pixels_sent++;
        if (sat == 0) grey_sent++;
    endtask

    // Drops valid, waits until every predicted pixel has come out and then
    // waits on so that nothing stray is still in flight.
    task automatic settle_pipeline();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (rgb_expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_CYC + 2) @(posedge i_clk);
    endtask

    // Random pixel, weighted toward the nominal ranges with a share of
    // sector edges, grey, full scale and values past 1.0 or 360 degrees.
    task automatic send_random_pixel();
        int                              pick;
        logic [hsv2rgb_pkg::HUE_W-1:0]   hue;
        logic [hsv2rgb_pkg::FRAC_W-1:0]  sat;
        logic [hsv2rgb_pkg::FRAC_W-1:0]  val;
        pick = $urandom_range(99);
        if (pick < 75) begin
            hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, 92159));
        end else if (pick < 88) begin
            hue = hsv2rgb_pkg::HUE_W'($urandom_range(1, 8) * 15360
                                      + $urandom_range(0, 4) - 2);
        end else begin
            hue = hsv2rgb_pkg::HUE_W'($urandom_range(0, 131071));
        end
        pick = $urandom_range(99);
        if (pick < 10)      sat = '0;
        else if (pick < 20) sat = hsv2rgb_pkg::ONE_Q8;
        else if (pick < 32) sat = hsv2rgb_pkg::FRAC_W'($urandom_range(257, 511));
        else                sat = hsv2rgb_pkg::FRAC_W'($urandom_range(1, 255));
        pick = $urandom_range(99);
        if (pick < 5)       val = '0;
        else if (pick < 15) val = hsv2rgb_pkg::ONE_Q8;
        else if (pick < 27) val = hsv2rgb_pkg::FRAC_W'($urandom_range(257, 511));
        else                val = hsv2rgb_pkg::FRAC_W'($urandom_range(0, 255));
        send_pixel(hue, sat, val);
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // The receiver stalls at random, or for a whole hold-off when one is
    // pending. Only this process writes i_out_ready.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left   = hold_left - 1;
        end else begin
            i_out_ready = !(out_idle_en && $urandom_range(99) < 7);
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        fail_count++;
        $display("ERROR %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // Every accepted RGB beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rgb_expected_q.size() == 0) begin
                report_mismatch("unexpected RGB beat, queue depth", 0, 1);
            end else begin
                want = rgb_expected_q.pop_front();
                if (o_red !== want.red)     report_mismatch("red", want.red, o_red);
                if (o_green !== want.green) report_mismatch("green", want.green, o_green);
                if (o_blue !== want.blue)   report_mismatch("blue", want.blue, o_blue);
                pixels_checked++;
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
            $display("hsv_to_rgb_converter_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Sector edges, hue past 360 degrees, grey pixels and the extremes of
    // saturation and brightness, including values above 1.0.
    task automatic test_directed_corners();
        send_pixel(17'd0,      9'd256, 9'd256);
        send_pixel(17'd15359,  9'd256, 9'd256);
        send_pixel(17'd15360,  9'd256, 9'd256);
        send_pixel(17'd30720,  9'd256, 9'd256);
        send_pixel(17'd46080,  9'd256, 9'd256);
        send_pixel(17'd61440,  9'd256, 9'd256);
        send_pixel(17'd76800,  9'd256, 9'd256);
        send_pixel(17'd92159,  9'd256, 9'd256);
        send_pixel(17'd92160,  9'd256, 9'd256);
        send_pixel(17'd122880, 9'd200, 9'd180);
        send_pixel(17'd131071, 9'd511, 9'd511);
        send_pixel(17'd40000,  9'd0,   9'd256);
        send_pixel(17'd0,      9'd0,   9'd0);
        send_pixel(17'd131071, 9'd0,   9'd511);
        send_pixel(17'd20000,  9'd511, 9'd511);
        send_pixel(17'd50000,  9'd257, 9'd128);
        send_pixel(17'd70000,  9'd1,   9'd256);
        send_pixel(17'd10000,  9'd255, 9'd1);
        send_pixel(17'd30000,  9'd256, 9'd0);
        send_pixel(17'd7680,   9'd128, 9'd200);
        send_pixel(17'd38400,  9'd200, 9'd100);
        send_pixel(17'd84480,  9'd256, 9'd256);
        settle_pipeline();
    endtask

    // The receiver holds off long enough for the pipeline to fill and push
    // back on the input while the sender keeps offering beats.
    task automatic test_output_holdoff();
        hold_left = HOLD_CYC;
        repeat (40) send_random_pixel();
        settle_pipeline();
    endtask

    // A long stretch with no idle cycles on either side, so beats move at
    // one per clock end to end.
    task automatic test_full_rate();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        repeat (150) send_random_pixel();
        settle_pipeline();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    // The bulk of the run: random pixels with random idling on both sides.
    task automatic test_random_stream();
        repeat (RANDOM_BEATS) send_random_pixel();
        settle_pipeline();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_output_holdoff();
        test_full_rate();
        test_random_stream();

        $display("Run covered %0d HSV pixels (%0d grey) and %0d checked RGB beats,",
                 pixels_sent, grey_sent, pixels_checked);
        $display("including sector edges, out-of-range inputs, a %0d-cycle hold-off %s",
                 HOLD_CYC, "and a full-rate stretch.");
        if (fail_count == 0) begin
            $display("hsv_to_rgb_converter_top: match");
        end else begin
            $display("hsv_to_rgb_converter_top: mismatch");
        end
        $finish;
    end

endmodule

@@ hsv_to_rgb_converter_top.f @@
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_sector.sv
sv/hsv2rgb_blend.sv
sv/hsv2rgb_scale.sv
sv/hsv_to_rgb_converter_top.sv
tb/tb_top.sv
